/* design/lsrc_pkg.sv */
// ----------------------------------------------------------------------------
// lsrc_pkg - shared definitions for the linear sample rate converter
// Widths, Q16 constants and the sequencer state type.
// ----------------------------------------------------------------------------
package lsrc_pkg;

  localparam int SAMPLE_W = 16;
  localparam int STEP_W   = 23;
  localparam int POS_W    = 24;
  localparam int FRAC_W   = 17;                 // 0 .. 1.0 in Q16
  localparam int DIFF_W   = SAMPLE_W + 1;
  localparam int PROD_W   = DIFF_W + FRAC_W + 1;
  localparam int NUM_W    = PROD_W + 1;
  localparam int CNT_W    = 6;                  // up to 64 results per sample

  localparam logic [POS_W-1:0]  ONE_Q16   = POS_W'(65536);
  localparam logic [STEP_W-1:0] STEP_MIN  = STEP_W'(1024);
  localparam logic [STEP_W-1:0] STEP_RST  = STEP_W'(65536);
  localparam logic [CNT_W-1:0]  CNT_LAST  = {CNT_W{1'b1}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = -16'sh8000;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_MUL  = 3'b010,
    S_ADD  = 3'b100
  } state_t;

endpackage

/* design/linear_sample_rate_converter_unit.sv */
// ----------------------------------------------------------------------------
// linear_sample_rate_converter_unit - mono 16-bit linear interpolation resampler
// Converts a signed 16-bit sample stream by a Q16 source/destination ratio.
// ----------------------------------------------------------------------------
// Each accepted input sample produces zero to 64 output samples; the final
// output of a sample carries last_of_run. Every output passes through S_MUL and
// S_ADD on one shared datapath: a 17x18 signed multiply of (cur - prev) by the
// Q16 fraction, then an add of prev*65536, round toward zero and load into the
// output register. A sample with outputs due therefore holds in_ready low until
// its last output is loaded (longer while the output register waits on
// out_ready); a sample with no output due is absorbed without leaving idle. The
// first sample after reset or after a ratio write is passed through unchanged.
// The output register lets the next input transfer while the last result of
// the previous one is still waiting. Writing cfg_wr_data clears all history; a
// ratio below 1024 (1/64) is used as 1024. Write the ratio only while idle.
// ----------------------------------------------------------------------------
module linear_sample_rate_converter_unit (
  input  logic                                    clk,
  input  logic                                    rst_n,
  // configuration
  input  logic                                    cfg_wr_en,
  input  logic [lsrc_pkg::STEP_W-1:0]             cfg_wr_data,
  // input channel
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic signed [lsrc_pkg::SAMPLE_W-1:0]    in_sample_in,
  // output channel
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [lsrc_pkg::SAMPLE_W-1:0]    out_sample_out,
  output logic                                    out_last_of_run
);

  lsrc_pkg::state_t                       state_r, state_nxt;
  logic [lsrc_pkg::STEP_W-1:0]            step_r;     // clamped at write
  logic signed [lsrc_pkg::SAMPLE_W-1:0]   prev_r;
  logic signed [lsrc_pkg::SAMPLE_W-1:0]   cur_r;
  logic                                   primed_r;
  logic [lsrc_pkg::POS_W-1:0]             pos_r;
  logic [lsrc_pkg::CNT_W-1:0]             cnt_r;
  logic signed [lsrc_pkg::PROD_W-1:0]     prod_r;
  logic                                   out_valid_r;
  logic signed [lsrc_pkg::SAMPLE_W-1:0]   out_data_r;
  logic                                   out_last_r;

  logic                                   in_xfer;
  logic                                   slot_free;
  logic signed [lsrc_pkg::DIFF_W-1:0]     diff;
  logic signed [lsrc_pkg::FRAC_W:0]       frac_s;
  logic signed [lsrc_pkg::NUM_W-1:0]      num;
  logic signed [lsrc_pkg::NUM_W-17:0]     quo;
  logic signed [lsrc_pkg::NUM_W-17:0]     quo_rz;
  logic signed [lsrc_pkg::SAMPLE_W-1:0]   interp;
  logic [lsrc_pkg::POS_W-1:0]             pos_adv;
  logic                                   is_last;

  assign in_ready  = (state_r == lsrc_pkg::S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;

  // multiply stage: (cur - prev) * frac, frac is at most 1.0 here
  assign diff   = lsrc_pkg::DIFF_W'(cur_r) - lsrc_pkg::DIFF_W'(prev_r);
  assign frac_s = {1'b0, pos_r[lsrc_pkg::FRAC_W-1:0]};

  // add stage: prev*65536 + product, then divide by 65536 toward zero
  assign num    = {{(lsrc_pkg::NUM_W-lsrc_pkg::SAMPLE_W-16){prev_r[lsrc_pkg::SAMPLE_W-1]}},
                   prev_r, 16'h0000} + lsrc_pkg::NUM_W'(prod_r);
  assign quo    = num[lsrc_pkg::NUM_W-1:16];
  assign quo_rz = (num[lsrc_pkg::NUM_W-1] && (num[15:0] != 16'h0000)) ?
                  quo + (lsrc_pkg::NUM_W-16)'(1) : quo;

  always_comb begin
    if (quo_rz > (lsrc_pkg::NUM_W-16)'(lsrc_pkg::SAMPLE_MAX)) begin
      interp = lsrc_pkg::SAMPLE_MAX;
    end else if (quo_rz < (lsrc_pkg::NUM_W-16)'(lsrc_pkg::SAMPLE_MIN)) begin
      interp = lsrc_pkg::SAMPLE_MIN;
    end else begin
      interp = quo_rz[lsrc_pkg::SAMPLE_W-1:0];
    end
  end

  assign pos_adv = pos_r + lsrc_pkg::POS_W'(step_r);
  assign is_last = (pos_adv > lsrc_pkg::ONE_Q16) || (cnt_r == lsrc_pkg::CNT_LAST);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lsrc_pkg::S_IDLE: begin
        if (in_xfer && (!primed_r || (pos_r <= lsrc_pkg::ONE_Q16))) begin
          state_nxt = lsrc_pkg::S_MUL;
        end
      end
      lsrc_pkg::S_MUL:  state_nxt = lsrc_pkg::S_ADD;
      lsrc_pkg::S_ADD: begin
        if (slot_free) begin
          state_nxt = is_last ? lsrc_pkg::S_IDLE : lsrc_pkg::S_MUL;
        end
      end
      default: state_nxt = lsrc_pkg::S_IDLE;
    endcase
  end

  // control and history
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lsrc_pkg::S_IDLE;
      step_r      <= lsrc_pkg::STEP_RST;
      prev_r      <= '0;
      primed_r    <= 1'b0;
      pos_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      // output register: load wins over drain
      if ((state_r == lsrc_pkg::S_ADD) && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_wr_en) begin
        step_r   <= (cfg_wr_data < lsrc_pkg::STEP_MIN) ? lsrc_pkg::STEP_MIN : cfg_wr_data;
        prev_r   <= '0;
        primed_r <= 1'b0;
        pos_r    <= '0;
      end else if (in_xfer) begin
        cnt_r <= '0;
        if (!primed_r) begin
          // first sample: land exactly on it
          primed_r <= 1'b1;
          pos_r    <= lsrc_pkg::ONE_Q16;
        end else if (pos_r > lsrc_pkg::ONE_Q16) begin
          // nothing due in this interval, just slide the window
          pos_r  <= pos_r - lsrc_pkg::ONE_Q16;
          prev_r <= in_sample_in;
        end
      end else if ((state_r == lsrc_pkg::S_ADD) && slot_free) begin
        cnt_r <= cnt_r + lsrc_pkg::CNT_W'(1);
        if (is_last) begin
          pos_r  <= (pos_adv > lsrc_pkg::ONE_Q16) ? pos_adv - lsrc_pkg::ONE_Q16 : '0;
          prev_r <= cur_r;
        end else begin
          pos_r <= pos_adv;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cur_r <= in_sample_in;
    end
    if (state_r == lsrc_pkg::S_MUL) begin
      prod_r <= lsrc_pkg::PROD_W'(diff) * lsrc_pkg::PROD_W'(frac_s);
    end
    if ((state_r == lsrc_pkg::S_ADD) && slot_free) begin
      out_data_r <= interp;
      out_last_r <= is_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_sample_out  = out_data_r;
  assign out_last_of_run = out_last_r;

endmodule
